// ===== rtl/core/rtsm_pkg.sv =====
// ---------------------------------------------------------------------------
// rtsm_pkg
// Shared types and codes of the radix tree size map.
// ---------------------------------------------------------------------------
package rtsm_pkg;

	localparam int BYTE_W = 8;
	localparam int CNT_W  = 9;

	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_REMOVE = 2'd1;
	localparam logic [1:0] FN_LOOKUP = 2'd2;

	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_ABSENT    = 2'd1;
	localparam logic [1:0] STS_OVERWROTE = 2'd2;
	localparam logic [1:0] STS_FULL      = 2'd3;

	typedef enum logic [11:0] {
		S_CLEAR   = 12'b0000_0000_0001,
		S_IDLE    = 12'b0000_0000_0010,
		S_WRD     = 12'b0000_0000_0100,
		S_WCHK    = 12'b0000_0000_1000,
		S_IINC_RD = 12'b0000_0001_0000,
		S_IINC_WR = 12'b0000_0010_0000,
		S_IALLOC  = 12'b0000_0100_0000,
		S_ILEAF   = 12'b0000_1000_0000,
		S_RCRD    = 12'b0001_0000_0000,
		S_RCWR    = 12'b0010_0000_0000,
		S_RESP    = 12'b0100_0000_0000,
		S_SPARE   = 12'b1000_0000_0000
	} state_t;

	typedef struct packed {
		logic take;
		logic give;
	} pool_req_t;

	typedef struct packed {
		logic grant;
	} pool_rsp_t;

endpackage

// ===== rtl/core/rtsm_ram.sv =====
// ---------------------------------------------------------------------------
// rtsm_ram
// Simple dual-port synchronous ram, one write and one registered read port.
// ---------------------------------------------------------------------------
module rtsm_ram #(
	parameter int AW = 8,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/rtsm_node_pool.sv =====
// ---------------------------------------------------------------------------
// rtsm_node_pool
// Free map of tree nodes; hands out the lowest free node, 32 nodes a cycle.
// ---------------------------------------------------------------------------
module rtsm_node_pool import rtsm_pkg::*; #(
	parameter int NODES = 64,
	parameter int NB    = 6,
	parameter int FW    = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pool_req_t     req,
	input  logic [NB-1:0] give_idx,
	output pool_rsp_t     rsp,
	output logic [NB-1:0] grant_idx,
	output logic [FW-1:0] free_cnt
);

	localparam int CH   = (NODES + 31) / 32;
	localparam int CWI  = (CH > 1) ? $clog2(CH) : 1;
	localparam int PADW = CH * 32;

	logic [NODES-1:0] free_q;
	logic [FW-1:0]    cnt_q;
	logic [CWI-1:0]   chk_q;
	logic [PADW-1:0]  pad;
	logic [31:0]      chunk;
	logic             hit;
	logic [4:0]       pos;

	assign pad   = PADW'(free_q);
	assign chunk = pad[chk_q*32 +: 32];

	always_comb begin
		hit = 1'b0;
		pos = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (chunk[i]) begin
				hit = 1'b1;
				pos = 5'(i);
			end
		end
	end

	assign grant_idx = NB'({chk_q, pos});
	assign rsp.grant = req.take & hit;
	assign free_cnt  = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
			cnt_q  <= FW'(NODES);
			chk_q  <= '0;
		end else begin
			if (rsp.grant) begin
				free_q[grant_idx] <= 1'b0;
				cnt_q             <= cnt_q - FW'(1);
				chk_q             <= '0;
			end else if (req.take) begin
				// no free node in this chunk, move on
				if (chk_q == CWI'(CH - 1)) begin
					chk_q <= '0;
				end else begin
					chk_q <= chk_q + CWI'(1);
				end
			end
			if (req.give) begin
				free_q[give_idx] <= 1'b1;
				cnt_q            <= cnt_q + FW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/radix_tree_size_map.sv =====
// ---------------------------------------------------------------------------
// radix_tree_size_map
// 256-way radix tree mapping an address key to a stored size.
// ---------------------------------------------------------------------------
// channel  direction  handshake              payload
// req      in         req_valid/req_ready    func, key, size_in
// rsp      out        rsp_valid/rsp_ready    status, size_out
//
// an item passes the accept state, one entry ram read and check per level (S_WRD,
// S_WCHK) and the response state; an insert that stores a new key adds a read
// and write of the parent count (none on an empty tree), one pool search per new
// node and one leaf write; a remove that finds its key adds a read and write per
// child count lowered: the last node's, plus one more for each node freed below
// the root. after reset all 2**clog2(NODES)*256 entries of the entry ram are swept
// before req_ready rises. one item at a time; the result register lets the next
// item in while it waits.
// ---------------------------------------------------------------------------
module radix_tree_size_map import rtsm_pkg::*; #(
	parameter int LEVELS    = 4,
	parameter int NODES     = 64,
	parameter int SIZE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  func,
	input  logic [31:0] key,
	input  logic [31:0] size_in,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  status,
	output logic [31:0] size_out
);

	localparam int NB = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int AW = NB + BYTE_W;
	localparam int PW = (SIZE_BITS > NB) ? SIZE_BITS : NB;
	localparam int DW = PW + 1;
	localparam int LW = $clog2(LEVELS);
	localparam int FW = $clog2(NODES + 1);

	state_t        state_q;
	logic [1:0]    func_q;
	logic [31:0]   key_q;
	logic [31:0]   size_q;
	logic [LW-1:0] lvl_q;
	logic [LW-1:0] lvl_dn;
	logic [NB-1:0] node_q;
	logic [NB-1:0] path_q [LEVELS];
	logic          root_q;
	logic [NB-1:0] root_node_q;
	logic          root_build_q;
	logic [AW-1:0] clr_q;
	logic [1:0]    st_q;
	logic [31:0]   sz_q;
	logic          rsp_valid_q;
	logic [1:0]    status_q;
	logic [31:0]   size_out_q;

	logic [7:0]    kb [LEVELS];
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] up_addr;
	logic [PW-1:0] sz_pw;

	logic          e_we;
	logic [AW-1:0] e_waddr;
	logic [DW-1:0] e_wdata;
	logic [DW-1:0] e_rdata;
	logic          ev;
	logic [PW-1:0] ep;

	logic             c_we;
	logic [NB-1:0]    c_waddr;
	logic [CNT_W-1:0] c_wdata;
	logic [CNT_W-1:0] c_rdata;
	logic [CNT_W-1:0] c_dec;

	pool_req_t     preq;
	pool_rsp_t     prsp;
	logic [NB-1:0] grant_idx;
	logic [FW-1:0] free_cnt;

	always_comb begin
		for (int i = 0; i < LEVELS; i++) begin
			kb[i] = 8'({32'd0, key_q} >> (8 * (LEVELS - 1 - i)));
		end
	end

	assign lvl_dn   = (lvl_q == '0) ? '0 : lvl_q - LW'(1);
	assign cur_addr = {node_q, kb[lvl_q]};
	assign up_addr  = {path_q[lvl_dn], kb[lvl_dn]};
	assign sz_pw    = PW'(SIZE_BITS'(size_q));
	assign ev       = e_rdata[PW];
	assign ep       = e_rdata[PW-1:0];
	assign c_dec    = c_rdata - CNT_W'(1);

	rtsm_ram #(.AW(AW), .DW(DW)) u_entry_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (cur_addr),
		.rdata (e_rdata)
	);

	rtsm_ram #(.AW(NB), .DW(CNT_W)) u_count_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (node_q),
		.rdata (c_rdata)
	);

	rtsm_node_pool #(.NODES(NODES), .NB(NB), .FW(FW)) u_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (preq),
		.give_idx  (node_q),
		.rsp       (prsp),
		.grant_idx (grant_idx),
		.free_cnt  (free_cnt)
	);

	// memory writes and pool requests
	always_comb begin
		e_we      = 1'b0;
		e_waddr   = cur_addr;
		e_wdata   = '0;
		c_we      = 1'b0;
		c_waddr   = node_q;
		c_wdata   = '0;
		preq.take = 1'b0;
		preq.give = 1'b0;
		case (state_q)
			S_CLEAR: begin
				e_we    = 1'b1;
				e_waddr = clr_q;
			end
			S_WCHK: begin
				if (lvl_q == LW'(LEVELS - 1) && ev) begin
					if (func_q == FN_INSERT) begin
						e_we    = 1'b1;
						e_wdata = {1'b1, sz_pw};
					end else if (func_q == FN_REMOVE) begin
						e_we = 1'b1;
					end
				end
			end
			S_IINC_WR: begin
				c_we    = 1'b1;
				c_wdata = c_rdata + CNT_W'(1);
			end
			S_IALLOC: begin
				preq.take = 1'b1;
				if (prsp.grant) begin
					// every new node ends up holding exactly one entry
					c_we    = 1'b1;
					c_waddr = grant_idx;
					c_wdata = CNT_W'(1);
					if (!root_build_q) begin
						e_we    = 1'b1;
						e_wdata = {1'b1, PW'(grant_idx)};
					end
				end
			end
			S_ILEAF: begin
				e_we    = 1'b1;
				e_wdata = {1'b1, sz_pw};
			end
			S_RCWR: begin
				c_we    = 1'b1;
				c_wdata = c_dec;
				if (c_dec == '0) begin
					preq.give = 1'b1;
					if (lvl_q != '0) begin
						e_we    = 1'b1;
						e_waddr = up_addr;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			root_q       <= 1'b0;
			root_node_q  <= '0;
			root_build_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
			lvl_q        <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && state_q != S_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						func_q <= func;
						key_q  <= key;
						size_q <= size_in;
						sz_q   <= '0;
						st_q   <= STS_OK;
						lvl_q  <= '0;
						if (func != FN_INSERT && func != FN_REMOVE && func != FN_LOOKUP) begin
							state_q <= S_RESP;
						end else if (!root_q) begin
							if (func != FN_INSERT) begin
								st_q    <= STS_ABSENT;
								state_q <= S_RESP;
							end else if (32'(free_cnt) < 32'(LEVELS)) begin
								st_q    <= STS_FULL;
								state_q <= S_RESP;
							end else begin
								root_build_q <= 1'b1;
								state_q      <= S_IALLOC;
							end
						end else begin
							node_q    <= root_node_q;
							path_q[0] <= root_node_q;
							state_q   <= S_WRD;
						end
					end
				end
				S_WRD: begin
					state_q <= S_WCHK;
				end
				S_WCHK: begin
					if (lvl_q != LW'(LEVELS - 1)) begin
						if (ev) begin
							node_q                <= ep[NB-1:0];
							path_q[lvl_q + LW'(1)] <= ep[NB-1:0];
							lvl_q                 <= lvl_q + LW'(1);
							state_q               <= S_WRD;
						end else if (func_q == FN_INSERT) begin
							// nodes missing below this level must all fit
							if (32'(free_cnt) < 32'(LEVELS - 1) - 32'(lvl_q)) begin
								st_q    <= STS_FULL;
								state_q <= S_RESP;
							end else begin
								state_q <= S_IINC_RD;
							end
						end else begin
							st_q    <= STS_ABSENT;
							state_q <= S_RESP;
						end
					end else if (!ev) begin
						if (func_q == FN_INSERT) begin
							state_q <= S_IINC_RD;
						end else begin
							st_q    <= STS_ABSENT;
							state_q <= S_RESP;
						end
					end else begin
						case (func_q)
							FN_INSERT: begin
								st_q    <= STS_OVERWROTE;
								state_q <= S_RESP;
							end
							FN_REMOVE: begin
								sz_q    <= 32'(ep[SIZE_BITS-1:0]);
								state_q <= S_RCRD;
							end
							default: begin
								sz_q    <= 32'(ep[SIZE_BITS-1:0]);
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_IINC_RD: begin
					state_q <= S_IINC_WR;
				end
				S_IINC_WR: begin
					if (lvl_q == LW'(LEVELS - 1)) begin
						state_q <= S_ILEAF;
					end else begin
						state_q <= S_IALLOC;
					end
				end
				S_IALLOC: begin
					if (prsp.grant) begin
						node_q <= grant_idx;
						if (root_build_q) begin
							root_q       <= 1'b1;
							root_node_q  <= grant_idx;
							root_build_q <= 1'b0;
						end else begin
							lvl_q <= lvl_q + LW'(1);
							if (lvl_q + LW'(1) == LW'(LEVELS - 1)) begin
								state_q <= S_ILEAF;
							end
						end
					end
				end
				S_ILEAF: begin
					state_q <= S_RESP;
				end
				S_RCRD: begin
					state_q <= S_RCWR;
				end
				S_RCWR: begin
					if (c_dec != '0) begin
						state_q <= S_RESP;
					end else if (lvl_q == '0) begin
						root_q      <= 1'b0;
						root_node_q <= '0;
						state_q     <= S_RESP;
					end else begin
						lvl_q   <= lvl_dn;
						node_q  <= path_q[lvl_dn];
						state_q <= S_RCRD;
					end
				end
				S_RESP: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						status_q    <= st_q;
						size_out_q  <= sz_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign size_out  = size_out_q;

`ifndef SYNTH
	a_grant_in_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		prsp.grant |-> state_q == S_IALLOC)
		else $error("node granted outside allocation");

	a_empty_tree_pool_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !root_q) |-> free_cnt == FW'(NODES))
		else $error("nodes held while tree is empty");

	a_no_count_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RCWR |-> c_rdata != '0)
		else $error("child count underflow");

	a_no_count_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IINC_WR |-> c_rdata < CNT_W'(256))
		else $error("child count overflow");
`endif

endmodule

// ===== sim/tb_radix_tree_size_map.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_radix_tree_size_map
// Drives insert, remove and lookup requests into the radix tree size map and
// compares every response with the table's values for directed items, else with a behavioral tree in the testbench.
// Covers empty-tree misses, overwrite, node pool exhaustion and node freeing,
// under random idling on both channels plus long response back-pressure.
// ---------------------------------------------------------------------------
module tb_radix_tree_size_map;
	import rtsm_pkg::*;

	localparam int LEVELS = 4;
	localparam int NODES  = 64;
	localparam int FANOUT = 256;
	localparam logic [1:0] FN_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int RANDOM_ITEMS = 650;
	localparam int HOLD_LEN = 300;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic [1:0]  func;
	logic [31:0] key;
	logic [31:0] size_in;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [1:0]  status;
	logic [31:0] size_out;

	radix_tree_size_map #(
		.LEVELS(LEVELS), .NODES(NODES), .SIZE_BITS(32)
	) u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.func(func), .key(key), .size_in(size_in),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.status(status), .size_out(size_out)
	);

	// behavioral tree
	bit          ent_used [NODES*FANOUT];
	logic [31:0] ent_data [NODES*FANOUT];
	int          kids     [NODES];
	bit          node_free[NODES];
	bit          have_root;
	int          root_idx;

	logic [1:0]  pending_status[$];
	logic [31:0] pending_size[$];
	logic [31:0] known_keys[$];

	int errors = 0;
	int accepted;
	int status_seen[4] = '{default: 0};
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_reqs = 0;
	int idle_cycles = 0;

	typedef struct {
		logic [1:0]  f;
		logic [31:0] k;
		logic [31:0] s;
		bit          typed;
		logic [1:0]  st;
		logic [31:0] so;
	} dir_row_t;

	dir_row_t dir_tbl[13] = '{
		'{FN_LOOKUP, 32'h0000_0000, 32'h0,         1'b1, STS_ABSENT,    32'h0},
		'{FN_REMOVE, 32'hFFFF_FFFF, 32'h0,         1'b1, STS_ABSENT,    32'h0},
		'{FN_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, STS_OK,        32'h0},
		'{FN_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, STS_OK,        32'h0},
		'{FN_INSERT, 32'hFFFF_FFFF, 32'h0,         1'b1, STS_OK,        32'h0},
		'{FN_LOOKUP, 32'h0000_0000, 32'h0,         1'b1, STS_OK,        32'hFFFF_FFFF},
		'{FN_INSERT, 32'h0000_0000, 32'h1234_5678, 1'b1, STS_OVERWROTE, 32'h0},
		'{FN_LOOKUP, 32'h0000_0000, 32'h0,         1'b1, STS_OK,        32'h1234_5678},
		'{FN_LOOKUP, 32'h0000_0001, 32'h0,         1'b1, STS_ABSENT,    32'h0},
		'{FN_REMOVE, 32'hFFFF_FFFF, 32'h0,         1'b1, STS_OK,        32'h0},
		'{FN_REMOVE, 32'hFFFF_FFFF, 32'h0,         1'b1, STS_ABSENT,    32'h0},
		'{FN_REMOVE, 32'h0000_0000, 32'h0,         1'b1, STS_OK,        32'h1234_5678},
		'{FN_LOOKUP, 32'h0000_0000, 32'h0,         1'b1, STS_ABSENT,    32'h0}
	};

	function automatic int key_byte(input logic [31:0] k, input int lvl);
		return int'((k >> (8 * (LEVELS - 1 - lvl))) & 32'hFF);
	endfunction

	function automatic int grab_node();
		for (int i = 0; i < NODES; i++) begin
			if (node_free[i]) begin
				node_free[i] = 1'b0;
				kids[i] = 0;
				for (int e = 0; e < FANOUT; e++) ent_used[i*FANOUT+e] = 1'b0;
				return i;
			end
		end
		return 0;
	endfunction

	// returns how many nodes of the path exist, 0 when the tree is empty
	function automatic int tree_walk(input logic [31:0] k, output int p[LEVELS]);
		int b;
		for (int i = 0; i < LEVELS; i++) p[i] = 0;
		if (!have_root) return 0;
		p[0] = root_idx;
		for (int i = 0; i < LEVELS - 1; i++) begin
			b = key_byte(k, i);
			if (!ent_used[p[i]*FANOUT+b]) return i + 1;
			p[i+1] = int'(ent_data[p[i]*FANOUT+b]) % NODES;
		end
		return LEVELS;
	endfunction

	function automatic void tree_apply(input logic [1:0] f, input logic [31:0] k,
			input logic [31:0] s, output logic [1:0] st, output logic [31:0] so);
		int p[LEVELS];
		int found;
		int nfree;
		int node;
		int b;
		int idx;
		st = STS_OK;
		so = '0;
		found = tree_walk(k, p);
		if (f == FN_INSERT) begin
			nfree = 0;
			foreach (node_free[i]) if (node_free[i]) nfree++;
			if (LEVELS - found > nfree) begin
				st = STS_FULL;
				return;
			end
			if (!have_root) begin
				root_idx = grab_node();
				have_root = 1'b1;
			end
			node = root_idx;
			for (int i = 0; i < LEVELS - 1; i++) begin
				b = key_byte(k, i);
				idx = node*FANOUT + b;
				if (!ent_used[idx]) begin
					ent_data[idx] = grab_node();
					ent_used[idx] = 1'b1;
					kids[node]++;
				end
				node = int'(ent_data[idx]) % NODES;
			end
			idx = node*FANOUT + key_byte(k, LEVELS - 1);
			if (ent_used[idx]) st = STS_OVERWROTE;
			else begin
				ent_used[idx] = 1'b1;
				kids[node]++;
			end
			ent_data[idx] = s;
		end else if (f == FN_REMOVE || f == FN_LOOKUP) begin
			idx = p[LEVELS-1]*FANOUT + key_byte(k, LEVELS - 1);
			if (found != LEVELS || !ent_used[idx]) begin
				st = STS_ABSENT;
				return;
			end
			so = ent_data[idx];
			if (f == FN_REMOVE) begin
				ent_used[idx] = 1'b0;
				kids[p[LEVELS-1]]--;
				// free emptied nodes walking back toward the root
				for (int i = LEVELS - 1; i > 0; i--) begin
					if (kids[p[i]] != 0) break;
					node_free[p[i]] = 1'b1;
					ent_used[p[i-1]*FANOUT + key_byte(k, i - 1)] = 1'b0;
					kids[p[i-1]]--;
				end
				if (kids[root_idx] == 0) begin
					node_free[root_idx] = 1'b1;
					have_root = 1'b0;
					root_idx = 0;
				end
			end
		end
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on %s at %0t: got %h expected %h", what, $realtime, got, want);
		errors++;
	endtask

	// one request transfer; predicts the response once accepted
	task automatic send_req(input logic [1:0] f, input logic [31:0] k,
			input logic [31:0] s, input bit typed, input logic [1:0] tst,
			input logic [31:0] tso);
		logic [1:0]  st;
		logic [31:0] so;
		if ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		req_valid <= 1'b1;
		func      <= f;
		key       <= k;
		size_in   <= s;
		do @(posedge clk); while (!req_ready);
		tree_apply(f, k, s, st, so);
		if (typed) begin
			st = tst;
			so = tso;
		end
		pending_status.push_back(st);
		pending_size.push_back(so);
		accepted++;
		if (f == FN_INSERT) begin
			known_keys.push_back(k);
			if (known_keys.size() > 80) void'(known_keys.pop_front());
		end
	endtask

	// upper bytes mostly from a few fixed values so paths share nodes; last byte random
	function automatic logic [31:0] pick_key();
		logic [31:0] k;
		logic [7:0] b;
		for (int i = 0; i < LEVELS; i++) begin
			case ($urandom_range(5))
				0: b = 8'h00;
				1: b = 8'hFF;
				2: b = 8'h5A;
				3: b = 8'hA5;
				default: b = 8'($urandom);
			endcase
			if (i == LEVELS - 1) b = 8'($urandom);
			k = {k[23:0], b};
		end
		return k;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// response side: random stalls plus requested long holds
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				rsp_ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_status.size() == 0) begin
				$display("unexpected response at %0t", $realtime);
				errors++;
			end else begin
				if (status !== pending_status[0])
					flag_mismatch("status", 32'(status), 32'(pending_status[0]));
				if (size_out !== pending_size[0])
					flag_mismatch("size_out", size_out, pending_size[0]);
				status_seen[pending_status[0]]++;
				void'(pending_status.pop_front());
				void'(pending_size.pop_front());
			end
		end
	end

	// watchdog on cycles without any transfer; covers the post-reset sweep
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("tb_radix_tree_size_map failed");
			$finish;
		end
	end

	initial begin
		int pick;
		logic [1:0] f;
		logic [31:0] k;
		req_valid = 1'b0;
		func = '0;
		key = '0;
		size_in = '0;
		accepted = 0;
		tx_idle_pct = 35;
		rx_idle_pct = 68;
		have_root = 1'b0;
		root_idx = 0;
		foreach (node_free[i]) node_free[i] = 1'b1;
		foreach (kids[i]) kids[i] = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);

		foreach (dir_tbl[i])
			send_req(dir_tbl[i].f, dir_tbl[i].k, dir_tbl[i].s, dir_tbl[i].typed,
				dir_tbl[i].st, dir_tbl[i].so);
		// fill the pool: a fresh top byte costs three nodes, the first four
		for (int i = 0; i <= 21; i++)
			send_req(FN_INSERT, {8'(i), 24'h0}, $urandom, 1'b0, STS_OK, '0);
		send_req(FN_INSERT, 32'h1400_0001, $urandom, 1'b0, STS_OK, '0);

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 68 : 0;
			rx_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 35 : 0;
			for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
				if (n == 50) hold_reqs++;
				if (n == 120) begin
					req_valid <= 1'b0;
					while (pending_size.size() != 0) @(posedge clk);
				end
				pick = $urandom_range(99);
				f = (pick < 45) ? FN_INSERT : (pick < 70) ? FN_REMOVE :
					(pick < 95) ? FN_LOOKUP : FN_NONE;
				if (f != FN_INSERT && known_keys.size() != 0 && $urandom_range(3) != 0)
					k = known_keys[$urandom_range(known_keys.size() - 1)];
				else
					k = pick_key();
				send_req(f, k, $urandom, 1'b0, STS_OK, '0);
			end
		end
		req_valid <= 1'b0;

		while (pending_size.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("%0d requests: %0d ok, %0d absent, %0d overwrite, %0d pool full",
			accepted, status_seen[STS_OK], status_seen[STS_ABSENT],
			status_seen[STS_OVERWROTE], status_seen[STS_FULL]);
		$display("idling on both channels, long response hold and drain pauses done");
		if (errors == 0) begin
			$display("tb_radix_tree_size_map passed");
		end else begin
			$display("tb_radix_tree_size_map failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/rtsm_pkg.sv
rtl/core/rtsm_ram.sv
rtl/core/rtsm_node_pool.sv
rtl/core/radix_tree_size_map.sv
sim/tb_radix_tree_size_map.sv
